// File: hdl/cva_pkg.sv
// Package: types, constants and helpers for the compass vector adder.
`default_nettype none
package cva_pkg;

    localparam int CORDIC_STEPS_DEF = 20;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAG_W    = 17;
    localparam int ANG_W    = 17;
    localparam int SMAG_W   = 18;
    localparam longint unsigned INV_K_Q30   = 64'd652032874;
    localparam longint unsigned RAD_NANODEG = 64'd57295779513;
    localparam longint unsigned NANO        = 64'd1000000000;
    localparam int unsigned ANG_MAX = 90000;
    localparam int unsigned MAG_MAX = 262143;

    typedef enum logic [1:0] {
        KIND_ANGLED = 2'd0,
        KIND_EW     = 2'd1,
        KIND_NS     = 2'd2
    } dir_kind_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_a;
        logic [ANG_W-1:0] angle_a;
        logic             north_a;
        logic             east_a;
        logic [MAG_W-1:0] mag_b;
        logic [ANG_W-1:0] angle_b;
        logic             north_b;
        logic             east_b;
    } in_item_t;

    typedef struct packed {
        logic [SMAG_W-1:0] sum_mag;
        logic [ANG_W-1:0]  sum_angle;
        logic              sum_north;
        logic              sum_east;
        dir_kind_t         dir_kind;
    } out_item_t;

    function automatic longint unsigned atan_nd(input int i);
        longint unsigned nd;
        begin
            unique case (i)
                0:  nd = 64'd45000000000;
                1:  nd = 64'd26565051177;
                2:  nd = 64'd14036243468;
                3:  nd = 64'd7125016349;
                4:  nd = 64'd3576334375;
                5:  nd = 64'd1789910608;
                6:  nd = 64'd895173710;
                7:  nd = 64'd447614171;
                8:  nd = 64'd223810500;
                9:  nd = 64'd111905677;
                10: nd = 64'd55952892;
                11: nd = 64'd27976453;
                12: nd = 64'd13988227;
                13: nd = 64'd6994114;
                14: nd = 64'd3497057;
                15: nd = 64'd1748528;
                default: nd = (RAD_NANODEG + (64'd1 << (i - 1))) >> i;
            endcase
            return nd;
        end
    endfunction

    // arctangent of 2^-i in degrees with fb fraction bits
    function automatic longint unsigned atan_q(input int i, input int fb);
        return ((atan_nd(i) << fb) + NANO / 2) / NANO;
    endfunction

endpackage
`default_nettype wire

// File: hdl/compass_vector_adder_core.sv
// Top level: polar to cartesian, sum, cartesian to polar, all pipelined.
//
//  channel | valid      | stall      | payload
//  in      | in_valid   | in_stall   | in_data  (in_item_t)
//  out     | out_valid  | out_stall  | out_data (out_item_t)
//
// One request per cycle while not stalled; stages in order: angle split,
// prescale, the rotation chain, sum, abs, the vectoring chain (one
// micro-rotation per stage), two gain stages and the output register.
// Reset empties all valid bits; payload registers are not reset.
// A stall holds the whole pipeline; in_stall is out_stall gated by out_valid,
// so the pipeline keeps advancing while the output register is empty.
`default_nettype none
module compass_vector_adder_core
    import cva_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);
    localparam int N  = CORDIC_STEPS;
    localparam int XW = MAG_W + FRAC_BITS + 4;   // per vector x/y
    localparam int SW = XW + 2;                  // sum and vectoring
    localparam int ZW = FRAC_BITS + 10;
    localparam int SBW = 4;
    localparam logic [ZW-1:0] ZONE = ZW'(64'd1);
    // reciprocals of 125: angle split and fractional part of the angle
    localparam longint unsigned Q125_REC = 64'd134218;
    localparam longint unsigned ZREC =
        ((64'd1 << (FRAC_BITS + 11)) + 64'd124) / 64'd125;

    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---- stage P: clamp angles, split each into quotient and remainder by 125
    function automatic logic [ANG_W-1:0] clamp_ang(input logic [ANG_W-1:0] a);
        return (a > ANG_W'(ANG_MAX)) ? ANG_W'(ANG_MAX) : a;
    endfunction

    function automatic logic [16:0] split125(input logic [ANG_W-1:0] a);
        logic [ANG_W+18-1:0] p;
        logic [9:0] q;
        logic [ANG_W-1:0] r;
        begin
            p = (ANG_W+18)'(a) * (ANG_W+18)'(Q125_REC);
            q = 10'(p >> 24);
            r = a - ANG_W'(q) * ANG_W'(125);
            return {q, r[6:0]};
        end
    endfunction

    logic [ANG_W-1:0] anga, angb;
    assign anga = clamp_ang(in_data.angle_a);
    assign angb = clamp_ang(in_data.angle_b);

    logic        vp_reg;
    in_item_t    dp_reg;
    logic [16:0] spa_reg, spb_reg;   // {angle / 125, angle % 125}
    logic [1:0]  axap_reg, axbp_reg; // {ang90, ang0}

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg   <= in_data;
            spa_reg  <= split125(anga);
            spb_reg  <= split125(angb);
            axap_reg <= {anga == ANG_W'(ANG_MAX), anga == '0};
            axbp_reg <= {angb == ANG_W'(ANG_MAX), angb == '0};
        end
    end

    // ---- stage 0: prescale and angle conversion
    logic               v0_reg;
    logic signed [XW-1:0] xa0_reg, xb0_reg;
    logic signed [ZW-1:0] za0_reg, zb0_reg;
    logic [3:0] sb0_reg;         // north_a east_a north_b east_b
    logic [1:0] axa0_reg, axb0_reg; // {ang90, ang0}
    logic [MAG_W-1:0] ma0_reg, mb0_reg;

    function automatic logic signed [XW-1:0] prescale(input logic [MAG_W-1:0] m);
        logic [MAG_W+30-1:0] p;
        begin
            p = (MAG_W+30)'(m) * (MAG_W+30)'(INV_K_Q30)
                + ((MAG_W+30)'(1) << (29 - FRAC_BITS));
            return XW'(p >> (30 - FRAC_BITS));
        end
    endfunction

    // round(a * 2^FB / 1000) = q * 2^(FB-3) + floor((r * 2^(FB-3) + 62) / 125)
    function automatic logic signed [ZW-1:0] ang2z(input logic [16:0] s);
        logic [FRAC_BITS+4-1:0] t;
        logic [2*FRAC_BITS+9-1:0] p;
        begin
            t = ((FRAC_BITS+4)'(s[6:0]) << (FRAC_BITS - 3)) + (FRAC_BITS+4)'(62);
            p = (2*FRAC_BITS+9)'(t) * (2*FRAC_BITS+9)'(ZREC);
            return ZW'((ZW'(s[16:7]) << (FRAC_BITS - 3)) + ZW'(p >> (FRAC_BITS + 11)));
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= vp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa0_reg <= prescale(dp_reg.mag_a);
            xb0_reg <= prescale(dp_reg.mag_b);
            za0_reg <= ang2z(spa_reg);
            zb0_reg <= ang2z(spb_reg);
            sb0_reg <= {dp_reg.north_a, dp_reg.east_a, dp_reg.north_b, dp_reg.east_b};
            axa0_reg <= axap_reg;
            axb0_reg <= axbp_reg;
            ma0_reg <= dp_reg.mag_a;
            mb0_reg <= dp_reg.mag_b;
        end
    end

    // ---- rotation chains; sideband carries sign bits, axis flags and magnitudes
    localparam int RSB = 4 + 4 + 2*MAG_W;
    logic               vr [0:N];
    logic signed [XW-1:0] xa [0:N], ya [0:N], xb [0:N], yb [0:N];
    logic signed [ZW-1:0] za [0:N], zb [0:N];
    logic [RSB-1:0]     sbr [0:N];
    logic               vdummy [0:N];
    logic [RSB-1:0]     sbdummy [0:N];

    assign vr[0] = v0_reg;
    assign xa[0] = xa0_reg;  assign ya[0] = '0;  assign za[0] = za0_reg;
    assign xb[0] = xb0_reg;  assign yb[0] = '0;  assign zb[0] = zb0_reg;
    assign sbr[0] = {sb0_reg, axa0_reg, axb0_reg, ma0_reg, mb0_reg};

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        cva_rot_stage #(.STEP(i), .FB(FRAC_BITS), .XW(XW), .ZW(ZW), .VECT(1'b0),
                        .SBW(RSB)) u_a (
            .clk, .rst_n, .en, .vin(vr[i]), .xin(xa[i]), .yin(ya[i]), .zin(za[i]),
            .sbin(sbr[i]), .vout(vr[i+1]), .xout(xa[i+1]), .yout(ya[i+1]),
            .zout(za[i+1]), .sbout(sbr[i+1]));
        cva_rot_stage #(.STEP(i), .FB(FRAC_BITS), .XW(XW), .ZW(ZW), .VECT(1'b0),
                        .SBW(RSB)) u_b (
            .clk, .rst_n, .en, .vin(vr[i]), .xin(xb[i]), .yin(yb[i]), .zin(zb[i]),
            .sbin(sbr[i]), .vout(vdummy[i+1]), .xout(xb[i+1]), .yout(yb[i+1]),
            .zout(zb[i+1]), .sbout(sbdummy[i+1]));
    end
    assign vdummy[0] = 1'b0;
    assign sbdummy[0] = '0;

    // ---- stage S: axis override, signs, sum
    logic [RSB-1:0] sbe;
    assign sbe = sbr[N];
    logic [MAG_W-1:0] mae, mbe;
    logic na, ea, nb, eb, a0, a90, b0, b90;
    assign {na, ea, nb, eb, a90, a0, b90, b0, mae, mbe} = sbe;

    logic signed [SW-1:0] pxa, pya, pxb, pyb, sx_next, sy_next;
    always_comb
    begin
        pxa = SW'(xa[N]); pya = SW'(ya[N]);
        pxb = SW'(xb[N]); pyb = SW'(yb[N]);
        if (a0)  begin pxa = SW'({mae, FRAC_BITS'(0)}); pya = '0; end
        if (a90) begin pxa = '0; pya = SW'({mae, FRAC_BITS'(0)}); end
        if (b0)  begin pxb = SW'({mbe, FRAC_BITS'(0)}); pyb = '0; end
        if (b90) begin pxb = '0; pyb = SW'({mbe, FRAC_BITS'(0)}); end
        if (!ea) pxa = -pxa;
        if (!na) pya = -pya;
        if (!eb) pxb = -pxb;
        if (!nb) pyb = -pyb;
        sx_next = pxa + pxb;
        sy_next = pya + pyb;
    end

    logic vs_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= 1'b0;
        else if (en)
            vs_reg <= vr[N];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    // ---- stage A: absolute values and case flags
    logic va_reg;
    logic signed [SW-1:0] ax_reg, ay_reg;
    logic [3:0] fa_reg; // north east xzero yzero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= vs_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= sx_reg[SW-1] ? -sx_reg : sx_reg;
            ay_reg <= sy_reg[SW-1] ? -sy_reg : sy_reg;
            fa_reg <= {!sy_reg[SW-1], !sx_reg[SW-1], sx_reg == '0, sy_reg == '0};
        end
    end

    // ---- vectoring chain
    logic vv [0:N];
    logic signed [SW-1:0] vx [0:N], vy [0:N];
    logic signed [ZW-1:0] vz [0:N];
    logic [3:0] vsb [0:N];
    assign vv[0] = va_reg; assign vx[0] = ax_reg; assign vy[0] = ay_reg;
    assign vz[0] = '0; assign vsb[0] = fa_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        cva_rot_stage #(.STEP(i), .FB(FRAC_BITS), .XW(SW), .ZW(ZW), .VECT(1'b1),
                        .SBW(4)) u_v (
            .clk, .rst_n, .en, .vin(vv[i]), .xin(vx[i]), .yin(vy[i]), .zin(vz[i]),
            .sbin(vsb[i]), .vout(vv[i+1]), .xout(vx[i+1]), .yout(vy[i+1]),
            .zout(vz[i+1]), .sbout(vsb[i+1]));
    end

    // axis magnitude is the unrotated component; carry it beside the chain
    logic signed [SW-1:0] axis_dly [0:N];
    assign axis_dly[0] = fa_reg[0] ? ax_reg : ay_reg;
    for (genvar i = 0; i < N; i++)
    begin : g_axd
        logic signed [SW-1:0] d_reg;
        always_ff @(posedge clk)
        begin
            if (en)
                d_reg <= axis_dly[i];
        end
        assign axis_dly[i+1] = d_reg;
    end

    // ---- stage M1: gain multiply split low/high partial products
    localparam int PW = 64;
    logic vm_reg;
    logic [3:0] fm_reg;
    logic [PW-1:0] plo_reg, phi_reg;
    logic signed [ZW-1:0] zm_reg;
    logic [SW-1:0] axm_reg;
    logic [SW-1:0] xpos;
    assign xpos = vx[N][SW-1] ? '0 : vx[N];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= vv[N];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= PW'(xpos[31:0]) * PW'(INV_K_Q30)
                       + (PW'(1) << (29 + FRAC_BITS));
            phi_reg <= PW'(xpos >> 32) * PW'(INV_K_Q30);
            zm_reg  <= vz[N][ZW-1] ? '0 : vz[N];
            fm_reg  <= vsb[N];
            axm_reg <= axis_dly[N];
        end
    end

    // ---- stage M2: finish magnitude, angle scale
    logic vn_reg;
    logic [3:0] fn_reg;
    logic [PW-1:0] mv_reg;
    logic [ZW+10-1:0] zs_reg;
    logic [SW-1:0] axn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg <= 1'b0;
        else if (en)
            vn_reg <= vm_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_reg  <= (phi_reg + (plo_reg >> 32)) >> (FRAC_BITS - 2);
            zs_reg  <= ((ZW+10)'(zm_reg) * (ZW+10)'(1000)
                        + ((ZW+10)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            fn_reg  <= fm_reg;
            axn_reg <= (axm_reg + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
    end

    // ---- output register
    out_item_t o_next;
    logic [PW-1:0] mg;
    logic [ZW+10-1:0] ag;
    always_comb
    begin
        if (fn_reg[1] && fn_reg[0])
        begin
            mg = '0; ag = '0;
        end
        else if (fn_reg[0])
        begin
            mg = PW'(axn_reg); ag = '0;
        end
        else if (fn_reg[1])
        begin
            mg = PW'(axn_reg); ag = (ZW+10)'(ANG_MAX);
        end
        else
        begin
            mg = mv_reg;
            ag = (zs_reg > (ZW+10)'(ANG_MAX)) ? (ZW+10)'(ANG_MAX) : zs_reg;
        end
        o_next.sum_mag   = (mg > PW'(MAG_MAX)) ? SMAG_W'(MAG_MAX) : SMAG_W'(mg);
        o_next.sum_angle = ANG_W'(ag);
        o_next.sum_north = fn_reg[3];
        o_next.sum_east  = fn_reg[2];
        if (ag == '0)
            o_next.dir_kind = KIND_EW;
        else if (ag == (ZW+10)'(ANG_MAX))
            o_next.dir_kind = KIND_NS;
        else
            o_next.dir_kind = KIND_ANGLED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vn_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= o_next;
    end

    logic unused;
    assign unused = ^{vdummy[N], sbdummy[N], ZONE};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.dir_kind == KIND_EW) == (out_data.sum_angle == '0))
        else $error("kind does not match angle");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.sum_angle <= ANG_W'(ANG_MAX))
        else $error("angle out of range");
endmodule
`default_nettype wire

// File: hdl/cva_rot_stage.sv
// One CORDIC micro-rotation (rotation or vectoring mode), registered.
`default_nettype none
module cva_rot_stage
    import cva_pkg::*;
#(
    parameter int STEP = 0,
    parameter int FB   = FRAC_BITS_DEF,
    parameter int XW   = 40,
    parameter int ZW   = 32,
    parameter bit VECT = 1'b0,
    parameter int SBW  = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  vin,
    input  wire logic signed [XW-1:0]  xin,
    input  wire logic signed [XW-1:0]  yin,
    input  wire logic signed [ZW-1:0]  zin,
    input  wire logic        [SBW-1:0] sbin,
    output logic                       vout,
    output logic signed [XW-1:0]       xout,
    output logic signed [XW-1:0]       yout,
    output logic signed [ZW-1:0]       zout,
    output logic        [SBW-1:0]      sbout
);
    localparam logic signed [ZW-1:0] A = ZW'(atan_q(STEP, FB));

    logic signed [XW-1:0] dx, dy, x_next, y_next;
    logic signed [ZW-1:0] z_next;
    logic dir;

    always_comb
    begin
        dx = yin >>> STEP;
        dy = xin >>> STEP;
        dir = VECT ? !yin[XW-1] : !zin[ZW-1];
        if (dir)
        begin
            x_next = VECT ? xin + dx : xin - dx;
            y_next = VECT ? yin - dy : yin + dy;
            z_next = VECT ? zin + A : zin - A;
        end
        else
        begin
            x_next = VECT ? xin - dx : xin + dx;
            y_next = VECT ? yin + dy : yin - dy;
            z_next = VECT ? zin - A : zin + A;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else if (en)
            vout <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xout  <= x_next;
            yout  <= y_next;
            zout  <= z_next;
            sbout <= sbin;
        end
    end
endmodule
`default_nettype wire
